// File: rtl/mru_list_update_core_assert.svh
// Assertion macros used by the file that checks the list core.
`ifndef MRU_LIST_UPDATE_CORE_ASSERT_SVH
`define MRU_LIST_UPDATE_CORE_ASSERT_SVH

// Whenever pre holds, post must hold in the same cycle (post may start with a delay).
`define MLU_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> post) \
        else $error(msg);

// Whenever pre holds, post must hold in the following cycle.
`define MLU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/mlu_pkg.sv
`timescale 1ns / 1ps

package mlu_pkg;

    // Sequencer states for one beat through the list.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_UPD
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic hit;
    } t_cell_ctrl;

    // Widths of the result fields.
    localparam int unsigned AGE_OUT_BITS = 4;
    localparam int unsigned ID_PORT_BITS = 16;

endpackage

// File: rtl/mlu_cell.sv
`timescale 1ns / 1ps

module mlu_cell #(
    parameter int unsigned DEPTH   = 16,
    parameter int unsigned ID_BITS = 16,
    parameter int unsigned INDEX   = 0
) (
    input  logic                       i_clk,
    input  mlu_pkg::t_cell_ctrl        i_ctrl,
    input  logic [ID_BITS-1:0]         i_id,
    input  logic [$clog2(DEPTH)-1:0]   i_ptr,
    input  logic [$clog2(DEPTH)-1:0]   i_hit_age,
    input  logic [ID_BITS-1:0]         i_next_entry,
    input  logic                       i_rst_n,
    output logic [ID_BITS-1:0]         o_entry,
    output logic                       o_match,
    output logic [ID_BITS-1:0]         o_old
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [ID_BITS-1:0] r_entry;
    logic [ID_BITS-1:0] n_entry;
    logic               r_match;
    logic [AW:0]        w_diff;
    logic [AW:0]        w_wrap;
    logic [AW-1:0]      w_age;

    // Distance of this slot behind the newest slot, modulo the depth.
    always_comb begin
        w_diff = {1'b0, i_ptr} - (AW+1)'(INDEX);
        w_wrap = w_diff + (AW+1)'(DEPTH);
        w_age  = w_diff[AW] ? w_wrap[AW-1:0] : w_diff[AW-1:0];
    end

    // On a hit the newest slot takes the identifier and the slots from the
    // matching one up to just below the newest take their newer neighbour;
    // on a miss the oldest slot takes the identifier.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.upd_en) begin
            if (i_ctrl.hit) begin
                if (w_age == '0) begin
                    n_entry = i_id;
                end else if (w_age <= i_hit_age) begin
                    n_entry = i_next_entry;
                end
            end else if (w_age == AW'(DEPTH - 1)) begin
                n_entry = i_id;
            end
        end
    end

    // The store clears to zero at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    // Registered compare against the identifier under work.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= (r_entry == i_id);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;
    assign o_old   = (w_age == AW'(DEPTH - 1)) ? r_entry : '0;

endmodule

// File: rtl/mru_list_update_core.sv
`timescale 1ns / 1ps
// Most-recently-used list of identifiers, built as a ring of cells.
// Input: drive i_item_id and raise start; the beat is taken at a rising edge
// where start is high and busy is low. Bits of i_item_id above ID_BITS are
// ignored.
// Output: o_valid is high for exactly one cycle with o_was_hit, o_hit_age and
// o_replaced_id; the receiver takes it at the end of that cycle and cannot
// stall the block.
// After the accepting edge the sequencer walks compare (all cells at once),
// lowest-slot select and a move of the cells, and the result register is
// loaded in the move state; busy stays high until the move is done, so a new
// item is taken only after the last one is through.
// Reset (synchronous, active low) clears every cell to zero and the newest
// pointer to slot zero, so identifier zero hits first; no result is pending
// after reset.
// The hit age is reported modulo 16.

module mru_list_update_core #(
    parameter int unsigned LIST_DEPTH = 16,
    parameter int unsigned ID_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [mlu_pkg::ID_PORT_BITS-1:0]    i_item_id,
    output logic                                busy,
    output logic                                o_valid,
    output logic                                o_was_hit,
    output logic [mlu_pkg::AGE_OUT_BITS-1:0]    o_hit_age,
    output logic [mlu_pkg::ID_PORT_BITS-1:0]    o_replaced_id
);

    localparam int unsigned AW = $clog2(LIST_DEPTH);

    mlu_pkg::t_state     r_state;
    mlu_pkg::t_state     n_state;
    mlu_pkg::t_cell_ctrl w_ctrl;

    logic [ID_BITS-1:0]  r_id;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       r_age;
    logic                r_hit;

    logic [ID_BITS-1:0]  w_entry [LIST_DEPTH];
    logic [ID_BITS-1:0]  w_old   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_match;
    logic [LIST_DEPTH-1:0] w_sel;
    logic [AW-1:0]       w_slot;
    logic [AW:0]         w_diff;
    logic [AW:0]         w_wrap;
    logic [AW-1:0]       w_age;
    logic [ID_BITS-1:0]  w_old_id;
    logic [ID_BITS+mlu_pkg::ID_PORT_BITS-1:0] w_id_wide;
    logic [ID_BITS+mlu_pkg::ID_PORT_BITS-1:0] w_old_wide;
    logic [AW+mlu_pkg::AGE_OUT_BITS-1:0]      w_age_wide;
    logic                w_accept;

    assign w_accept = start && !busy;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlu_pkg::ST_IDLE: begin
                if (start) n_state = mlu_pkg::ST_CMP;
            end
            mlu_pkg::ST_CMP: n_state = mlu_pkg::ST_SEL;
            mlu_pkg::ST_SEL: n_state = mlu_pkg::ST_UPD;
            mlu_pkg::ST_UPD: n_state = mlu_pkg::ST_IDLE;
            default:         n_state = mlu_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        busy          = 1'b1;
        w_ctrl.cmp_en = 1'b0;
        w_ctrl.upd_en = 1'b0;
        w_ctrl.hit    = r_hit;
        unique case (r_state)
            mlu_pkg::ST_IDLE: busy = 1'b0;
            mlu_pkg::ST_CMP:  w_ctrl.cmp_en = 1'b1;
            mlu_pkg::ST_SEL:  ;
            mlu_pkg::ST_UPD:  w_ctrl.upd_en = 1'b1;
            default:          busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the identifier of an accepted beat, keeping its low ID_BITS.
    assign w_id_wide = {{ID_BITS{1'b0}}, i_item_id};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id <= w_id_wide[ID_BITS-1:0];
        end
    end

    // Ring of cells; each one's newer neighbour is the next slot up.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        mlu_cell #(
            .DEPTH   (LIST_DEPTH),
            .ID_BITS (ID_BITS),
            .INDEX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_id         (r_id),
            .i_ptr        (r_ptr),
            .i_hit_age    (r_age),
            .i_next_entry (w_entry[(g + 1) % LIST_DEPTH]),
            .i_rst_n      (i_rst_n),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g]),
            .o_old        (w_old[g])
        );
    end

    // The lowest matching slot wins.
    assign w_sel = w_match & (~w_match + LIST_DEPTH'(1));

    always_comb begin
        w_slot   = '0;
        w_old_id = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_sel[i]) w_slot = w_slot | AW'(i);
            w_old_id = w_old_id | w_old[i];
        end
        w_diff = {1'b0, r_ptr} - {1'b0, w_slot};
        w_wrap = w_diff + (AW+1)'(LIST_DEPTH);
        w_age  = w_diff[AW] ? w_wrap[AW-1:0] : w_diff[AW-1:0];
    end

    // Hit flag and age, held for the move cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == mlu_pkg::ST_SEL) begin
            r_hit <= (w_match != '0);
            r_age <= w_age;
        end
    end

    // The newest pointer advances on a miss.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (w_ctrl.upd_en && !r_hit) begin
            r_ptr <= (r_ptr == AW'(LIST_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
        end
    end

    // Result register, loaded in the move cycle.
    assign w_old_wide = {{mlu_pkg::ID_PORT_BITS{1'b0}}, w_old_id};
    assign w_age_wide = {{mlu_pkg::AGE_OUT_BITS{1'b0}}, r_age};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_ctrl.upd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.upd_en) begin
            o_was_hit     <= r_hit;
            o_hit_age     <= r_hit ? w_age_wide[mlu_pkg::AGE_OUT_BITS-1:0] : '0;
            o_replaced_id <= r_hit ? '0 : w_old_wide[mlu_pkg::ID_PORT_BITS-1:0];
        end
    end

`include "mru_list_update_core_assert.svh"

`MLU_ASSERT_IMPL(a_result_follows, w_accept, ##4 o_valid, "accepted beat gave no result")
`MLU_ASSERT_IMPL(a_one_winner, r_state == mlu_pkg::ST_SEL, $onehot0(w_sel), "several slots selected")
`MLU_ASSERT_IMPL(a_hit_fields, o_valid && o_was_hit, o_replaced_id == '0, "hit reports a victim")
`MLU_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe repeated")

endmodule
